// ===== src/rss_pkg.sv =====
package rss_pkg;

	localparam int SCORE_W = 32;
	localparam int TAG_W   = 6;
	localparam int RANK_W  = 7;

	// register reset value of keep_count
	localparam logic [RANK_W-1:0] KEEP_RESET = 7'd64;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} rss_state_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [TAG_W-1:0]          tag;
	} rss_entry_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic load;   // place the broadcast entry
		logic drain;  // shift the whole chain one cell toward the head
	} rss_cell_ctrl_t;

endpackage

// ===== src/rss_if.sv =====
interface rss_in_if;
	import rss_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] score;
	logic [TAG_W-1:0]          tag;
	logic                      last_in;

	modport source (output valid, score, tag, last_in, input ready);
	modport sink   (input valid, score, tag, last_in, output ready);
endinterface

interface rss_out_if;
	import rss_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] sorted_score;
	logic [TAG_W-1:0]          sorted_tag;
	logic [RANK_W-1:0]         rank;
	logic                      overflow;
	logic                      last_out;

	modport source (output valid, sorted_score, sorted_tag, rank, overflow, last_out,
		input ready);
	modport sink   (input valid, sorted_score, sorted_tag, rank, overflow, last_out,
		output ready);
endinterface

// ===== src/ranked_score_sorter.sv =====
// ranked_score_sorter: ascending sort of one set of (score, tag) entries
//
// entries (sink): one request per entry, score is signed Q16.16, lower is better.
//   an entry is placed in the insertion chain in the cycle it is accepted, so
//   loading runs at one entry per clock. last_in marks the final entry of a set.
// ranked (source): after last_in the block emits the lowest min(keep_count,
//   stored) entries with rank 1, 2, ..., one request per cycle while the
//   receiver is ready; last_out marks the final one, overflow is 1 on every
//   result of a set that lost entries because all STORE_DEPTH cells were full.
//   equal scores leave in reverse arrival order.
// latency: the first result is valid the cycle after the last entry is taken.
// sets do not overlap: entries.ready is low while results drain, since the
//   output shifts the same chain of cells that holds the sorted set.
// receiver stall: the head cell and rank simply hold until ranked.ready rises.
// cfg_we/cfg_wdata write keep_count (0 acts as 1); write it only between sets.
// reset: arst_n clears the fill count, overflow flag and state; keep_count
//   returns to 64. cell contents are not reset, only cells below the fill
//   count are ever read.
module ranked_score_sorter #(
	parameter int STORE_DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	rss_in_if.sink                    entries,
	rss_out_if.source                 ranked,
	input  logic                      cfg_we,
	input  logic [rss_pkg::RANK_W-1:0] cfg_wdata
);
	import rss_pkg::*;

	localparam int CNT_W = $clog2(STORE_DEPTH + 1);

	rss_state_t          state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic                drop_q;
	logic [RANK_W-1:0]   keep_q;
	logic [RANK_W-1:0]   n_q;
	logic [RANK_W-1:0]   rank_q;

	logic                in_acc, out_acc, room, insert, run_done;
	logic [CNT_W-1:0]    count_after;
	logic [RANK_W-1:0]   keep_eff, stored;

	rss_entry_t          new_entry;
	rss_entry_t          cell_entry [STORE_DEPTH];
	logic                cell_shift [STORE_DEPTH];
	rss_cell_ctrl_t      ctrl;

	// handshakes
	assign in_acc   = entries.valid && entries.ready;
	assign out_acc  = ranked.valid && ranked.ready;
	assign room     = count_q < CNT_W'(STORE_DEPTH);
	assign insert   = in_acc && room;
	assign run_done = out_acc && (rank_q == n_q);

	// fill count including the entry just offered
	assign count_after = count_q + CNT_W'(room);
	assign keep_eff    = (keep_q == '0) ? RANK_W'(1) : keep_q;
	assign stored      = RANK_W'(count_after);

	assign new_entry.score = entries.score;
	assign new_entry.tag   = entries.tag;

	assign ctrl.load  = insert;
	assign ctrl.drain = out_acc;

	// insertion chain: head cell holds the lowest score
	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		rss_entry_t prev_e, next_e;
		logic       prev_s;
		logic       occ;

		if (i == 0) begin : g_head
			assign prev_e = new_entry;
			assign prev_s = 1'b0;
		end else begin : g_body
			assign prev_e = cell_entry[i-1];
			assign prev_s = cell_shift[i-1];
		end

		// tail takes its own value on drain, no result of the run reads that copy
		if (i == STORE_DEPTH - 1) begin : g_tail
			assign next_e = cell_entry[i];
		end else begin : g_mid
			assign next_e = cell_entry[i+1];
		end

		assign occ = CNT_W'(i) < count_q;

		rss_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_shift (prev_s),
			.next_entry (next_e),
			.occupied   (occ),
			.entry      (cell_entry[i]),
			.shift      (cell_shift[i])
		);
	end

	// sequencer: load entries, then drain ranked results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		entries.ready = 1'b0;
		ranked.valid  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				entries.ready = 1'b1;
				if (in_acc && entries.last_in) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				ranked.valid = 1'b1;
				if (run_done) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// fill count, overflow flag, rank counter and run length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
			rank_q  <= RANK_W'(1);
			n_q     <= RANK_W'(1);
		end else begin
			if (insert) begin
				count_q <= count_after;
			end
			if (in_acc && !room) begin
				drop_q <= 1'b1;
			end
			if (in_acc && entries.last_in) begin
				rank_q <= RANK_W'(1);
				n_q    <= (stored < keep_eff) ? stored : keep_eff;
			end
			if (out_acc) begin
				rank_q <= rank_q + RANK_W'(1);
			end
			if (run_done) begin
				count_q <= '0;
				drop_q  <= 1'b0;
			end
		end
	end

	// keep_count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
		end else if (cfg_we) begin
			keep_q <= cfg_wdata;
		end
	end

	// result comes straight from the head cell
	assign ranked.sorted_score = cell_entry[0].score;
	assign ranked.sorted_tag   = cell_entry[0].tag;
	assign ranked.rank         = rank_q;
	assign ranked.overflow     = drop_q;
	assign ranked.last_out     = rank_q == n_q;
endmodule

// ===== src/rss_cell.sv =====
module rss_cell (
	input  logic                   clk,
	input  rss_pkg::rss_cell_ctrl_t ctrl,
	input  rss_pkg::rss_entry_t    new_entry,
	input  rss_pkg::rss_entry_t    prev_entry,
	input  logic                   prev_shift,
	input  rss_pkg::rss_entry_t    next_entry,
	input  logic                   occupied,
	output rss_pkg::rss_entry_t    entry,
	output logic                   shift
);
	import rss_pkg::*;

	rss_entry_t entry_q;

	// empty cells and cells holding a score >= the new one move down
	assign shift = !occupied || (entry_q.score >= new_entry.score);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			entry_q <= next_entry;
		end else if (ctrl.load && shift) begin
			entry_q <= prev_shift ? prev_entry : new_entry;
		end
	end
endmodule

// ===== src/rss_checker.sv =====
module rss_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       in_last,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [rss_pkg::RANK_W-1:0] out_rank,
	input logic                       out_last
);
	import rss_pkg::*;

	// loading and draining never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while results pending");

	// a stalled result keeps its rank
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_rank))
		else $error("stalled result changed");

	// last entry starts a run at rank 1
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> out_valid && out_rank == RANK_W'(1))
		else $error("run did not start at rank 1");

	// ranks count up by one inside a run
	a_rank_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=>
			out_valid && out_rank == $past(out_rank) + RANK_W'(1))
		else $error("rank did not advance");

	// the final result hands back to loading
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> in_ready && !out_valid)
		else $error("block not ready after last result");
endmodule

bind ranked_score_sorter rss_checker u_rss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (entries.valid),
	.in_ready  (entries.ready),
	.in_last   (entries.last_in),
	.out_valid (ranked.valid),
	.out_ready (ranked.ready),
	.out_rank  (ranked.rank),
	.out_last  (ranked.last_out)
);
